@@ rtl/http_chunked_body_decoder_defines.svh @@
// assertion macros shared by the chunked body decoder rtl
// expects a clock named clk and an active-low reset named rst_n in the using scope
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// same-cycle implication
`define HCBD_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCBD_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hcbd_pkg.sv @@
// types and constants for the chunked body decoder
// no dependencies
package hcbd_pkg;

    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_SIZE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE_LF  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DATA     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA_CR  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA_LF  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_FINAL_CR = 3'd5;
    localparam logic [PHASE_W-1:0] PH_FINAL_LF = 3'd6;
    localparam logic [PHASE_W-1:0] PH_DONE     = 3'd7;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BADCHAR  = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_CRLF     = 2'd3;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_message;
    } in_item_t;

    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        logic        message_done;
        logic [31:0] body_length;
        logic [1:0]  error_code;
    } out_item_t;

    // hex digit decode, either letter case; bit 4 flags a valid digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

@@ rtl/hcbd_core.sv @@
// per-byte decode step and message state of the chunked body decoder
// depends on hcbd_pkg
module hcbd_core #(
    parameter int SIZE_BITS   = 32,
    parameter int LENGTH_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  hcbd_pkg::in_item_t  item,
    output hcbd_pkg::out_item_t result
);

    logic [hcbd_pkg::PHASE_W-1:0] phase_reg, phase_cur, phase_next;
    logic [SIZE_BITS-1:0]         chunk_reg, chunk_cur, chunk_next;
    logic                         seen_reg, seen_cur, seen_next;
    logic [LENGTH_BITS-1:0]       total_reg, total_cur, total_next;
    logic [1:0]                   err_reg, err_cur, err_next;
    logic [4:0]                   hex;
    logic                         body_valid;
    logic                         done;
    logic [31:0]                  length32;
    logic [7:0]                   b;

    assign b   = item.data_byte;
    assign hex = hcbd_pkg::hex_decode(b);

    always_comb
    begin
        // a new message starts from the reset state
        phase_cur = item.new_message ? hcbd_pkg::PH_SIZE  : phase_reg;
        chunk_cur = item.new_message ? '0                 : chunk_reg;
        seen_cur  = item.new_message ? 1'b0               : seen_reg;
        total_cur = item.new_message ? '0                 : total_reg;
        err_cur   = item.new_message ? hcbd_pkg::ERR_NONE : err_reg;

        phase_next = phase_cur;
        chunk_next = chunk_cur;
        seen_next  = seen_cur;
        total_next = total_cur;
        err_next   = err_cur;
        body_valid = 1'b0;
        done       = 1'b0;

        if (err_cur == hcbd_pkg::ERR_NONE)
        begin
            case (phase_cur)
                hcbd_pkg::PH_SIZE:
                begin
                    if (hex[4])
                    begin
                        // another digit fits only if the top nibble is still clear
                        if (chunk_cur[SIZE_BITS-1 -: 4] != 4'd0)
                            err_next = hcbd_pkg::ERR_OVERFLOW;
                        else
                        begin
                            chunk_next = {chunk_cur[SIZE_BITS-5:0], hex[3:0]};
                            seen_next  = 1'b1;
                        end
                    end
                    else if (b == hcbd_pkg::CH_CR && seen_cur)
                        phase_next = hcbd_pkg::PH_SIZE_LF;
                    else
                        err_next = hcbd_pkg::ERR_BADCHAR;
                end
                hcbd_pkg::PH_SIZE_LF:
                begin
                    if (b != hcbd_pkg::CH_LF)
                        err_next = hcbd_pkg::ERR_CRLF;
                    else if (chunk_cur == '0)
                    begin
                        done       = 1'b1;
                        phase_next = hcbd_pkg::PH_FINAL_CR;
                    end
                    else
                        phase_next = hcbd_pkg::PH_DATA;
                end
                hcbd_pkg::PH_DATA:
                begin
                    body_valid = 1'b1;
                    if (total_cur != '1)
                        total_next = total_cur + LENGTH_BITS'(1);
                    chunk_next = chunk_cur - SIZE_BITS'(1);
                    if (chunk_cur == SIZE_BITS'(1))
                        phase_next = hcbd_pkg::PH_DATA_CR;
                end
                hcbd_pkg::PH_DATA_CR:
                begin
                    if (b != hcbd_pkg::CH_CR)
                        err_next = hcbd_pkg::ERR_CRLF;
                    else
                        phase_next = hcbd_pkg::PH_DATA_LF;
                end
                hcbd_pkg::PH_DATA_LF:
                begin
                    if (b != hcbd_pkg::CH_LF)
                        err_next = hcbd_pkg::ERR_CRLF;
                    else
                    begin
                        phase_next = hcbd_pkg::PH_SIZE;
                        chunk_next = '0;
                        seen_next  = 1'b0;
                    end
                end
                hcbd_pkg::PH_FINAL_CR:
                begin
                    if (b != hcbd_pkg::CH_CR)
                        err_next = hcbd_pkg::ERR_CRLF;
                    else
                        phase_next = hcbd_pkg::PH_FINAL_LF;
                end
                hcbd_pkg::PH_FINAL_LF:
                begin
                    if (b != hcbd_pkg::CH_LF)
                        err_next = hcbd_pkg::ERR_CRLF;
                    else
                        phase_next = hcbd_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = phase_cur;
                end
            endcase
        end
    end

    // reported length saturates at 32 bits
    generate
        if (LENGTH_BITS > 32)
        begin : g_len_wide
            assign length32 = (|total_next[LENGTH_BITS-1:32]) ? 32'hFFFF_FFFF
                                                               : total_next[31:0];
        end
        else
        begin : g_len_narrow
            assign length32 = 32'(total_next);
        end
    endgenerate

    always_comb
    begin
        result.body_valid   = body_valid;
        result.body_byte    = body_valid ? b : 8'd0;
        result.message_done = done;
        result.body_length  = length32;
        result.error_code   = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hcbd_pkg::PH_SIZE;
            chunk_reg <= '0;
            seen_reg  <= 1'b0;
            total_reg <= '0;
            err_reg   <= hcbd_pkg::ERR_NONE;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            chunk_reg <= chunk_next;
            seen_reg  <= seen_next;
            total_reg <= total_next;
            err_reg   <= err_next;
        end
    end

endmodule

@@ rtl/http_chunked_body_decoder.sv @@
// chunked body decoder top level: input register, decode step, result register
// depends on hcbd_pkg, hcbd_core and http_chunked_body_decoder_defines.svh
// Decodes an HTTP/1.1 chunked body one byte per cycle when the result side
// does not stall. Each accepted byte transaction gives exactly one result
// transaction, registered first in the input register and then, through the
// decode step that updates the message state, in the result register. The
// input side keeps accepting while a result waits, as long as the input
// register is free or draining. Errors (bad size character, size overflow,
// missing CR LF) latch until a byte arrives with new_message set.
`include "http_chunked_body_decoder_defines.svh"

module http_chunked_body_decoder #(
    parameter int SIZE_BITS   = 32,
    parameter int LENGTH_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  hcbd_pkg::in_item_t  byte_data,
    output logic                result_valid,
    input  logic                result_stall,
    output hcbd_pkg::out_item_t result_data
);

    logic                s1_valid_reg, s1_valid_next;
    hcbd_pkg::in_item_t  s1_item_reg;
    logic                res_valid_reg, res_valid_next;
    hcbd_pkg::out_item_t res_data_reg;
    hcbd_pkg::out_item_t step_result;
    logic                accept;
    logic                adv;

    assign adv        = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign byte_stall = s1_valid_reg && !adv;
    assign accept     = byte_valid && !byte_stall;

    assign result_valid = res_valid_reg;
    assign result_data  = res_data_reg;

    hcbd_core #(
        .SIZE_BITS   (SIZE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (adv),
        .item    (s1_item_reg),
        .result  (step_result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (adv)
            res_valid_next = 1'b1;
        else if (!result_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= byte_data;
        if (adv)
            res_data_reg <= step_result;
    end

    `HCBD_ASSERT_NEXT(a_s1_kept, s1_valid_reg && !adv, s1_valid_reg, "input transaction dropped")
    `HCBD_ASSERT_NOW(a_done_not_body, result_valid,
        !(result_data.message_done && result_data.body_valid), "done together with body byte")
    `HCBD_ASSERT_NOW(a_err_no_body, result_valid && result_data.error_code != hcbd_pkg::ERR_NONE,
        !result_data.body_valid, "body byte while error latched")
    `HCBD_ASSERT_NOW(a_body_zero, result_valid && !result_data.body_valid,
        result_data.body_byte == 8'd0, "body byte not zero when idle")
    `HCBD_ASSERT_NEXT(a_res_loaded, adv, result_valid, "decoded transaction not presented")

endmodule
